// File: hw/rtl/llpt_pkg.sv
package llpt_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 4096;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   localparam int SIZE_W      = 13;
   localparam int THRESHOLD_W = 8;
   localparam int HALF_W      = 12;
   localparam int RED_W       = 8;
   localparam int RSP_POS_W   = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [SIZE_W-1:0]      RESET_FRAME_WIDTH  = 13'd1280;
   localparam logic [SIZE_W-1:0]      RESET_FRAME_HEIGHT = 13'd960;
   localparam logic [THRESHOLD_W-1:0] RESET_RED_THRESHOLD = 8'd100;
   localparam logic [HALF_W-1:0]      RESET_HALF_WIDTH   = 12'd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_RED_THRESHOLD = 2'd2,
      CSR_HALF_WIDTH   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0]      frame_width;
      logic [SIZE_W-1:0]      frame_height;
      logic [THRESHOLD_W-1:0] red_threshold;
      logic [HALF_W-1:0]      window_half_width;
   } cfg_type;

   typedef struct packed {
      logic is_hit;
      logic last;
   } flags_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } queue_ctrl_type;

endpackage

// File: hw/rtl/llpt_req_if.sv
interface llpt_req_if import llpt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RED_W-1:0] red_level;

   modport source (output valid, output red_level, input ready);
   modport sink   (input valid, input red_level, output ready);
endinterface

// File: hw/rtl/llpt_rsp_if.sv
interface llpt_rsp_if import llpt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 is_hit;
   logic [RSP_POS_W-1:0] hit_row;
   logic [RSP_POS_W-1:0] hit_column;
   logic                 frame_done;
   logic [RSP_POS_W-1:0] column_average;
   logic                 no_points;

   modport source (output valid, output is_hit, output hit_row, output hit_column,
                   output frame_done, output column_average, output no_points,
                   input ready);
   modport sink   (input valid, input is_hit, input hit_row, input hit_column,
                   input frame_done, input column_average, input no_points,
                   output ready);
endinterface

// File: hw/rtl/llpt_front.sv
module llpt_front import llpt_pkg::*; #(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   localparam int CW     = $clog2(MAX_WIDTH),
   localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
   localparam int NW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
   localparam int SW     = CW + NW,
   localparam int DATA_W = $bits(flags_type) + RW + CW + SW + NW
) (
   input  logic              clock,
   input  logic              reset,
   llpt_req_if.sink          req_if,
   input  cfg_type           cfg,
   input  logic              queue_full,
   output logic              push,
   output logic [DATA_W-1:0] push_data
);

   localparam int XW = ((CW > HALF_W) ? CW : HALF_W) + 1;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW:0]   right_ff, right_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [NW-1:0] cnt_ff, cnt_in;

   logic          start, accept, hit, col_wrap, row_wrap, last;
   logic [CW:0]   w, col_plus;
   logic [RW:0]   h, row_plus;
   logic [CW-1:0] left_cur, left_new;
   logic [CW:0]   right_cur, right_new;
   logic [SW-1:0] sum_cur;
   logic [NW-1:0] cnt_cur;
   logic [XW-1:0] col_x, hw_x, w_x, reach_x;
   flags_type     flags;

   always_comb begin
      if (cfg.frame_width == '0) begin
         w = (CW+1)'(1);
      end else if ({1'b0, cfg.frame_width} > 14'(MAX_WIDTH)) begin
         w = (CW+1)'(MAX_WIDTH);
      end else begin
         w = (CW+1)'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         h = (RW+1)'(1);
      end else if ({1'b0, cfg.frame_height} > 14'(MAX_HEIGHT)) begin
         h = (RW+1)'(MAX_HEIGHT);
      end else begin
         h = (RW+1)'(cfg.frame_height);
      end
   end

   assign start     = (col_ff == '0) && (row_ff == '0);
   assign left_cur  = start ? '0 : left_ff;
   assign right_cur = start ? w : right_ff;
   assign sum_cur   = start ? '0 : sum_ff;
   assign cnt_cur   = start ? '0 : cnt_ff;

   assign hit = (col_ff >= left_cur) && ({1'b0, col_ff} < right_cur)
                && (req_if.red_level > cfg.red_threshold);

   assign col_x     = XW'(col_ff);
   assign hw_x      = XW'(cfg.window_half_width);
   assign w_x       = XW'(w);
   assign reach_x   = col_x + hw_x;
   assign right_new = (reach_x > w_x) ? w : (CW+1)'(reach_x);
   assign left_new  = (col_x >= hw_x) ? CW'(col_x - hw_x) : '0;

   assign col_plus = {1'b0, col_ff} + (CW+1)'(1);
   assign row_plus = {1'b0, row_ff} + (RW+1)'(1);
   assign col_wrap = col_plus >= w;
   assign row_wrap = row_plus >= h;
   assign last     = col_wrap && row_wrap;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      right_in = right_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         left_in  = hit ? left_new : left_cur;
         right_in = hit ? right_new : right_cur;
         sum_in   = hit ? sum_cur + SW'(col_ff) : sum_cur;
         cnt_in   = hit ? cnt_cur + NW'(1) : cnt_cur;
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : RW'(row_plus);
         end else begin
            col_in = CW'(col_plus);
         end
      end
   end

   assign flags.is_hit = hit;
   assign flags.last   = last;
   assign push         = accept && (hit || last);
   assign push_data    = {flags, row_ff, col_ff, sum_in, cnt_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
         right_ff <= w;
         sum_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/llpt_queue.sv
module llpt_queue import llpt_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              full,
   output logic              empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [KW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = count_ff == KW'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + KW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/llpt_back.sv
module llpt_back import llpt_pkg::*; #(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   localparam int CW     = $clog2(MAX_WIDTH),
   localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
   localparam int NW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
   localparam int SW     = CW + NW,
   localparam int DATA_W = $bits(flags_type) + RW + CW + SW + NW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [DATA_W-1:0] entry,
   input  logic              q_empty,
   output logic              pop,
   llpt_rsp_if.source        rsp_if
);

   localparam int TW = $clog2(SW + 1);

   typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_type;

   state_type     state_ff, state_in;
   flags_type     e_flags;
   logic [RW-1:0] e_row;
   logic [CW-1:0] e_col;
   logic [SW-1:0] e_sum;
   logic [NW-1:0] e_cnt;

   logic [NW-1:0] div_cnt_ff, div_cnt_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dq_ff, dq_in;
   logic [TW-1:0] step_ff, step_in;
   flags_type     pend_flags_ff, pend_flags_in;
   logic [RW-1:0] pend_row_ff, pend_row_in;
   logic [CW-1:0] pend_col_ff, pend_col_in;

   logic                 valid_ff, valid_in;
   logic                 is_hit_ff, is_hit_in;
   logic [RSP_POS_W-1:0] row_ff, row_in;
   logic [RSP_POS_W-1:0] col_ff, col_in;
   logic                 done_ff, done_in;
   logic [RSP_POS_W-1:0] avg_ff, avg_in;
   logic                 nopts_ff, nopts_in;

   logic          out_free, needs_div, take_bit;
   logic [NW:0]   rem_shift;

   assign {e_flags, e_row, e_col, e_sum, e_cnt} = entry;

   assign out_free  = !valid_ff || rsp_if.ready;
   assign needs_div = e_flags.last && (e_cnt != '0);
   assign rem_shift = {rem_ff, dq_ff[SW-1]};
   assign take_bit  = rem_shift >= {1'b0, div_cnt_ff};

   always_comb begin
      state_in      = state_ff;
      pop           = 1'b0;
      div_cnt_in    = div_cnt_ff;
      rem_in        = rem_ff;
      dq_in         = dq_ff;
      step_in       = step_ff;
      pend_flags_in = pend_flags_ff;
      pend_row_in   = pend_row_ff;
      pend_col_in   = pend_col_ff;
      valid_in      = valid_ff;
      is_hit_in     = is_hit_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      done_in       = done_ff;
      avg_in        = avg_ff;
      nopts_in      = nopts_ff;

      if (valid_ff && rsp_if.ready) begin
         valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               if (needs_div) begin
                  pop           = 1'b1;
                  div_cnt_in    = e_cnt;
                  rem_in        = '0;
                  dq_in         = e_sum;
                  step_in       = TW'(SW);
                  pend_flags_in = e_flags;
                  pend_row_in   = e_row;
                  pend_col_in   = e_col;
                  state_in      = S_DIV;
               end else if (out_free) begin
                  pop       = 1'b1;
                  valid_in  = 1'b1;
                  is_hit_in = e_flags.is_hit;
                  row_in    = e_flags.is_hit ? RSP_POS_W'(e_row) : '0;
                  col_in    = e_flags.is_hit ? RSP_POS_W'(e_col) : '0;
                  done_in   = e_flags.last;
                  avg_in    = '0;
                  nopts_in  = e_flags.last;
               end
            end
         end
         S_DIV: begin
            rem_in  = take_bit ? NW'(rem_shift - {1'b0, div_cnt_ff}) : NW'(rem_shift);
            dq_in   = {dq_ff[SW-2:0], take_bit};
            step_in = step_ff - TW'(1);
            if (step_ff == TW'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               valid_in  = 1'b1;
               is_hit_in = pend_flags_ff.is_hit;
               row_in    = pend_flags_ff.is_hit ? RSP_POS_W'(pend_row_ff) : '0;
               col_in    = pend_flags_ff.is_hit ? RSP_POS_W'(pend_col_ff) : '0;
               done_in   = 1'b1;
               avg_in    = RSP_POS_W'(dq_ff);
               nopts_in  = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
      div_cnt_ff    <= div_cnt_in;
      rem_ff        <= rem_in;
      dq_ff         <= dq_in;
      pend_flags_ff <= pend_flags_in;
      pend_row_ff   <= pend_row_in;
      pend_col_ff   <= pend_col_in;
      is_hit_ff     <= is_hit_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      done_ff       <= done_in;
      avg_ff        <= avg_in;
      nopts_ff      <= nopts_in;
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.is_hit         = is_hit_ff;
   assign rsp_if.hit_row        = row_ff;
   assign rsp_if.hit_column     = col_ff;
   assign rsp_if.frame_done     = done_ff;
   assign rsp_if.column_average = avg_ff;
   assign rsp_if.no_points      = nopts_ff;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !pop)
      else $error("queue popped outside idle");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("pop from empty queue");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_cnt_ff != '0) && (step_ff != '0))
      else $error("divide running with zero divisor or step");

endmodule

// File: hw/rtl/laser_line_pixel_tracker.sv
// Laser line pixel tracker.
// req_if carries one red level per transaction, in raster order; the block
// counts column and row itself against frame_width and frame_height.
// rsp_if carries one transaction for each hit pixel and one for the last
// pixel of each frame (a single transaction when both apply), holding the
// row and column of the hit and, at frame end, the mean hit column or the
// no_points flag.
// The csr_ port writes one register per cycle with csr_write_enable high;
// write it only while no pixel is in flight.
// Throughput: one pixel per cycle while req_if.ready is high. A result passes
// through the queue to the registered rsp_if outputs; the frame-end mean waits
// for the one-bit-per-cycle divider in the back stage.
// A 4-entry queue sits between the pixel classifier and the result stage,
// so pixels keep flowing during the divide or while rsp_if stalls, until
// the queue fills and req_if.ready drops.
// Reset restores the register defaults and starts a new frame at pixel 0.
module laser_line_pixel_tracker import llpt_pkg::*; #(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   llpt_req_if.sink               req_if,
   llpt_rsp_if.source             rsp_if,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int NW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int SW     = CW + NW;
   localparam int DATA_W = $bits(flags_type) + RW + CW + SW + NW;

   cfg_type           cfg_ff, cfg_in;
   queue_ctrl_type    qc;
   logic [DATA_W-1:0] push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:   cfg_in.frame_width       = csr_write_data;
            CSR_FRAME_HEIGHT:  cfg_in.frame_height      = csr_write_data;
            CSR_RED_THRESHOLD: cfg_in.red_threshold     = csr_write_data[THRESHOLD_W-1:0];
            CSR_HALF_WIDTH:    cfg_in.window_half_width = csr_write_data[HALF_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width       <= RESET_FRAME_WIDTH;
         cfg_ff.frame_height      <= RESET_FRAME_HEIGHT;
         cfg_ff.red_threshold     <= RESET_RED_THRESHOLD;
         cfg_ff.window_half_width <= RESET_HALF_WIDTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   llpt_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg_ff),
      .queue_full (qc.full),
      .push       (qc.push),
      .push_data  (push_data)
   );

   llpt_queue #(
      .DATA_W (DATA_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (qc.push),
      .push_data (push_data),
      .pop       (qc.pop),
      .pop_data  (pop_data),
      .full      (qc.full),
      .empty     (qc.empty)
   );

   llpt_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .entry   (pop_data),
      .q_empty (qc.empty),
      .pop     (qc.pop),
      .rsp_if  (rsp_if)
   );

endmodule

// File: test/laser_line_pixel_tracker_test.sv
`timescale 1ns / 1ps

module laser_line_pixel_tracker_test;
   import llpt_pkg::*;

   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 64;
   localparam int RANDOM_PIXELS = 1050;
   localparam int EDGE_PIXELS   = 200;

   typedef struct packed {
      logic                 is_hit;
      logic [RSP_POS_W-1:0] hit_row;
      logic [RSP_POS_W-1:0] hit_column;
      logic                 frame_done;
      logic [RSP_POS_W-1:0] column_average;
      logic                 no_points;
   } pixel_report_type;

   class tracker_scoreboard;
      logic [SIZE_W-1:0]      width_reg;
      logic [SIZE_W-1:0]      height_reg;
      logic [THRESHOLD_W-1:0] threshold_reg;
      logic [HALF_W-1:0]      half_reg;
      int unsigned            col_pos;
      int unsigned            row_pos;
      int unsigned            left_edge;
      int unsigned            right_edge;
      int unsigned            hit_total;
      longint unsigned        col_sum;
      pixel_report_type       pending[$];
      int                     errors;
      int                     pixels;
      int                     hits;
      int                     frames;
      int                     settings;

      function new();
         width_reg     = RESET_FRAME_WIDTH;
         height_reg    = RESET_FRAME_HEIGHT;
         threshold_reg = RESET_RED_THRESHOLD;
         half_reg      = RESET_HALF_WIDTH;
         col_pos       = 0;
         row_pos       = 0;
         left_edge     = 0;
         right_edge    = RESET_FRAME_WIDTH;
         hit_total     = 0;
         col_sum       = 0;
         errors        = 0;
         pixels        = 0;
         hits          = 0;
         frames        = 0;
         settings      = 0;
      endfunction

      function int unsigned clamp_size(int unsigned value, int unsigned limit);
         if (value < 1) return 1;
         if (value > limit) return limit;
         return value;
      endfunction

      function int unsigned columns();
         return clamp_size(width_reg, DEFAULT_MAX_WIDTH);
      endfunction

      function int unsigned rows();
         return clamp_size(height_reg, DEFAULT_MAX_HEIGHT);
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_FRAME_WIDTH:   width_reg = value;
            CSR_FRAME_HEIGHT:  height_reg = value;
            CSR_RED_THRESHOLD: threshold_reg = value[THRESHOLD_W-1:0];
            CSR_HALF_WIDTH:    half_reg = value[HALF_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(logic [RED_W-1:0] red);
         int unsigned      w;
         int unsigned      h;
         int unsigned      c;
         int unsigned      r;
         int unsigned      reach;
         bit               hit;
         bit               last;
         pixel_report_type res;
         w = columns();
         h = rows();
         if (col_pos == 0 && row_pos == 0) begin
            left_edge  = 0;
            right_edge = w;
            col_sum    = 0;
            hit_total  = 0;
         end
         c = col_pos;
         r = row_pos;
         hit = (c >= left_edge) && (c < right_edge) && (red > threshold_reg);
         if (hit) begin
            reach      = c + half_reg;
            right_edge = (reach > w) ? w : reach;
            left_edge  = (c >= half_reg) ? c - half_reg : 0;
            col_sum   += c;
            hit_total++;
         end
         last = (c + 1 >= w) && (r + 1 >= h);
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
         pixels++;
         if (hit || last) begin
            res = '0;
            if (hit) begin
               res.is_hit     = 1'b1;
               res.hit_row    = r[RSP_POS_W-1:0];
               res.hit_column = c[RSP_POS_W-1:0];
               hits++;
            end
            if (last) begin
               res.frame_done = 1'b1;
               frames++;
               if (hit_total == 0) begin
                  res.no_points = 1'b1;
               end else begin
                  res.column_average = RSP_POS_W'(col_sum / hit_total);
               end
            end
            pending.insert(pending.size(), res);
         end
      endfunction

      task log_error(string msg);
         errors++;
         if (errors <= 50) $display("ERROR at %0t: %s", $time, msg);
      endtask

      task compare(string name, logic [RSP_POS_W-1:0] got, logic [RSP_POS_W-1:0] want);
         if (got !== want)
            log_error($sformatf("%s got %0d, expected %0d", name, got, want));
      endtask

      task check_result(pixel_report_type got);
         pixel_report_type want;
         if (pending.size() == 0) begin
            log_error("result transaction with none pending");
            return;
         end
         want = pending.pop_front();
         compare("is_hit", RSP_POS_W'(got.is_hit), RSP_POS_W'(want.is_hit));
         compare("hit_row", got.hit_row, want.hit_row);
         compare("hit_column", got.hit_column, want.hit_column);
         compare("frame_done", RSP_POS_W'(got.frame_done), RSP_POS_W'(want.frame_done));
         compare("column_average", got.column_average, want.column_average);
         compare("no_points", RSP_POS_W'(got.no_points), RSP_POS_W'(want.no_points));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   llpt_req_if req_bus();
   llpt_rsp_if rsp_bus();

   tracker_scoreboard sb;
   bit                steady;
   int                line_center;
   int                quiet_cycles = 0;

   laser_line_pixel_tracker u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // bright spot around a center column that drifts from row to row
   function automatic logic [RED_W-1:0] laser_red();
      int          spread;
      int          limit;
      logic [7:0]  t;
      t     = sb.threshold_reg;
      limit = sb.columns() - 1;
      if (sb.col_pos == 0) begin
         line_center = line_center + $urandom_range(0, 4) - 2;
         if (line_center < 0) line_center = 0;
         if (line_center > limit) line_center = limit;
      end
      spread = int'(sb.col_pos) - line_center;
      if (spread < 0) spread = -spread;
      if ($urandom_range(0, 99) < 8) return RED_W'($urandom_range(0, 255));
      if (spread <= 1) return (t == 8'd255) ? 8'd255 : RED_W'($urandom_range(t + 1, 255));
      return RED_W'($urandom_range(0, t));
   endfunction

   task automatic send_pixel(input logic [RED_W-1:0] red);
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.red_level <= red;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_pixel(red);
      if (!steady && $urandom_range(0, 199) == 0) begin
         // hold until every pending result is out
         req_bus.valid <= 1'b0;
         while (sb.pending.size() != 0) @(posedge clock);
         @(posedge clock);
      end else begin
         gap = steady ? 0 : idle_length();
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_laser(input int count);
      for (int i = 0; i < count; i++) send_pixel(laser_red());
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] width, input logic [CSR_DATA_W-1:0] height,
                               input logic [CSR_DATA_W-1:0] threshold,
                               input logic [CSR_DATA_W-1:0] half);
      write_reg(CSR_FRAME_WIDTH, width);
      write_reg(CSR_FRAME_HEIGHT, height);
      write_reg(CSR_RED_THRESHOLD, threshold);
      write_reg(CSR_HALF_WIDTH, half);
      csr_write_enable <= 1'b0;
      sb.settings++;
      line_center = $urandom_range(0, sb.columns() - 1);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result('{rsp_bus.is_hit, rsp_bus.hit_row, rsp_bus.hit_column,
                           rsp_bus.frame_done, rsp_bus.column_average, rsp_bus.no_points});
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("laser_line_pixel_tracker: mismatch");
         $finish;
      end
   end

   initial begin
      int run;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         run = $urandom_range(1, 40);
         rsp_bus.ready <= 1'b1;
         repeat (run) @(posedge clock);
         run = steady ? 0 : idle_length();
         if (run > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (run) @(posedge clock);
         end
      end
   end

   initial begin
      int                    roll;
      int                    count;
      int                    sent;
      logic [CSR_DATA_W-1:0] width;
      logic [CSR_DATA_W-1:0] height;
      logic [CSR_DATA_W-1:0] threshold;
      logic [CSR_DATA_W-1:0] half;
      sb = new();
      steady      = 1'b0;
      line_center = 0;
      req_bus.valid     <= 1'b0;
      req_bus.red_level <= '0;
      csr_write_enable  <= 1'b0;
      csr_index         <= CSR_FRAME_WIDTH;
      csr_write_data    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero half width: a hit closes the window for the rest of the frame
      write_config(13'd5, 13'd2, 13'd0, 13'd0);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd1);
      send_pixel(8'd128);
      send_pixel(8'd255);
      settle();

      // threshold at maximum: no hit possible, frame ends with no points
      write_config(13'd3, 13'd1, 13'd255, 13'd4095);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd255);
      settle();

      // zero sizes saturate to one pixel: hit and frame end together
      write_config(13'd0, 13'd0, 13'd254, 13'd4095);
      send_pixel(8'd255);
      send_pixel(8'd254);
      settle();

      // shrink the width in mid-row: the row ends after the next pixel
      write_config(13'd6, 13'd2, 13'd100, 13'd1);
      send_pixel(8'd50);
      send_pixel(8'd60);
      send_pixel(8'd200);
      send_pixel(8'd255);
      settle();
      write_config(13'd2, 13'd2, 13'd100, 13'd1);
      send_pixel(8'd255);
      send_pixel(8'd255);
      send_pixel(8'd255);
      settle();

      // widest row: columns run far past any small width
      write_config(13'd4096, 13'd1, 13'd100, 13'd4095);
      send_laser(EDGE_PIXELS);
      settle();

      // one column, oversized height register
      steady = 1'b1;
      write_config(13'd1, 13'd8191, 13'($urandom_range(0, 200)), 13'd1);
      send_laser(EDGE_PIXELS);
      steady = 1'b0;
      settle();

      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) width = CSR_DATA_W'($urandom_range(1, 24));
         else if (roll < 86) width = '0;
         else if (roll < 92) width = CSR_DATA_W'($urandom_range(4096, 8191));
         else width = CSR_DATA_W'($urandom_range(25, 4095));
         roll = $urandom_range(0, 99);
         if (roll < 85) height = CSR_DATA_W'($urandom_range(1, 8));
         else if (roll < 92) height = '0;
         else height = CSR_DATA_W'($urandom_range(9, 8191));
         roll = $urandom_range(0, 99);
         if (roll < 10) threshold = '0;
         else if (roll < 20) threshold = CSR_DATA_W'(255);
         else threshold = CSR_DATA_W'($urandom_range(0, 255));
         if ($urandom_range(0, 9) < 3)
            threshold[CSR_DATA_W-1:THRESHOLD_W] = (CSR_DATA_W-THRESHOLD_W)'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 70) half = CSR_DATA_W'($urandom_range(0, 8));
         else if (roll < 78) half = '0;
         else if (roll < 86) half = CSR_DATA_W'(4095);
         else half = CSR_DATA_W'($urandom_range(0, 4095));
         if ($urandom_range(0, 9) < 3) half[CSR_DATA_W-1] = 1'b1;
         steady = ($urandom_range(0, 3) == 0);
         write_config(width, height, threshold, half);
         count = $urandom_range(10, 90);
         send_laser(count);
         sent += count;
         steady = 1'b0;
         settle();
      end

      $display("Sent %0d pixels over %0d register settings;", sb.pixels, sb.settings);
      $display("checked %0d hit reports and %0d frame ends.", sb.hits, sb.frames);
      if (sb.errors == 0)
         $display("laser_line_pixel_tracker: match");
      else
         $display("laser_line_pixel_tracker: mismatch");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/llpt_pkg.sv
hw/rtl/llpt_req_if.sv
hw/rtl/llpt_rsp_if.sv
hw/rtl/llpt_front.sv
hw/rtl/llpt_queue.sv
hw/rtl/llpt_back.sv
hw/rtl/laser_line_pixel_tracker.sv
test/laser_line_pixel_tracker_test.sv
